// File: sv/arg_pkg.sv
// ============================================================================
// arg_pkg - shared types for the address region table
// Entry layout, cell control and flag groups, action and status codes.
// ============================================================================
package arg_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic [31:0] start_addr;
        logic [31:0] end_addr;
        logic [7:0]  flags;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     lh_load;
        logic     lh_value;
        logic     flag_en;
    } cell_ctrl_t;

    typedef struct packed {
        logic ge;
        logic strict_hit;
        logic loose_hit;
    } cell_flags_t;

endpackage

// File: sv/arg_cell.sv
// ============================================================================
// arg_cell - one slot of the sorted region table
// Holds one region and its last-hit mark, compares it against the current
// transfer, and loads, keeps or takes its lower neighbor's region on commit.
// ============================================================================
module arg_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  arg_pkg::cell_ctrl_t  ctrl,
    input  arg_pkg::entry_t      new_entry,
    input  logic [31:0]          lookup_address,
    input  logic                 entry_valid,
    input  arg_pkg::entry_t      prev_entry,
    input  logic                 prev_last_hit,
    output arg_pkg::entry_t      entry,
    output logic                 last_hit,
    output arg_pkg::cell_flags_t flags
);
    import arg_pkg::*;

    entry_t      entry_reg;
    logic        lh_reg;
    cell_flags_t flags_reg;
    cell_flags_t flags_next;

    always_comb
    begin
        flags_next.ge         = entry_valid && (entry_reg.start_addr <= new_entry.start_addr);
        flags_next.strict_hit = entry_valid && (entry_reg.start_addr < lookup_address)
                                && (lookup_address < entry_reg.end_addr);
        flags_next.loose_hit  = entry_valid && (entry_reg.start_addr <= lookup_address)
                                && (lookup_address < entry_reg.end_addr);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.flag_en)
        begin
            flags_reg <= flags_next;
        end
        case (ctrl.op)
            CELL_LOAD:  entry_reg <= new_entry;
            CELL_SHIFT: entry_reg <= prev_entry;
            default:    entry_reg <= entry_reg;
        endcase
    end

    // The last-hit mark travels with its region when the row shifts up.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lh_reg <= 1'b0;
        end
        else if (ctrl.lh_load)
        begin
            lh_reg <= ctrl.lh_value;
        end
        else
        begin
            case (ctrl.op)
                CELL_LOAD:  lh_reg <= 1'b0;
                CELL_SHIFT: lh_reg <= prev_last_hit;
                default:    lh_reg <= lh_reg;
            endcase
        end
    end

    assign entry    = entry_reg;
    assign last_hit = lh_reg;
    assign flags    = flags_reg;

endmodule

// File: sv/address_region_table.sv
// ============================================================================
// address_region_table - sorted address region table with last-hit cache
// A row of cells keeps the regions sorted by start; lookups try the last
// hit first, then take the lowest matching region.
// ============================================================================
//  channel   direction  tdata (low bit up)                          tuser
//  s_axis    in         start 32, end 32, flags 8, address 32      action 2
//  m_axis    out        index 4, start 32, end 32, flags 8,        status 2
//                       count 5, zero pad 7
//
// Each item passes through its transfer, a compare phase in which every cell
// compares its region against the transfer, and a commit in which the row
// shifts or marks and the result is registered. The next transfer is taken
// in the cycle after the commit, so a new item waits for the last to commit.
// A stalled output only holds the commit of the following item.
// Reset empties the table at once; no clearing pass is needed.
// ============================================================================
module address_region_table #(
    parameter int MAX_REGIONS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [103:0]  s_axis_tdata,   // region_start, region_end, region_flags, lookup_address
    input  logic [1:0]    s_axis_tuser,   // action
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [87:0]   m_axis_tdata,   // region_index, found_start, found_end, found_flags,
                                          // region_count, zero pad
    output logic [1:0]    m_axis_tuser    // status
);
    import arg_pkg::*;

    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);

    logic [1:0]       cmd_action_reg;
    entry_t           cmd_entry_reg;
    logic [31:0]      cmd_addr_reg;
    logic             cmd_valid_reg;
    logic             cmp_done_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    logic [3:0]       out_index_reg;
    entry_t           out_entry_reg;
    logic [4:0]       out_count_reg;

    entry_t           cell_entry [MAX_REGIONS];
    cell_flags_t      cell_flags [MAX_REGIONS];
    cell_ctrl_t       cell_ctrl  [MAX_REGIONS];
    logic [MAX_REGIONS-1:0] lh_vec;
    logic [MAX_REGIONS-1:0] valid_vec;
    logic [MAX_REGIONS-1:0] ge_vec;
    logic [MAX_REGIONS-1:0] strict_vec;
    logic [MAX_REGIONS-1:0] loose_vec;
    logic [MAX_REGIONS-1:0] ins_onehot;
    logic [MAX_REGIONS-1:0] strict_sel;
    logic [MAX_REGIONS-1:0] first_loose;
    logic [MAX_REGIONS-1:0] hit_sel;
    logic             strict_hit;
    logic             any_hit;
    logic             full;
    logic [IW-1:0]    ins_idx;
    logic [IW-1:0]    hit_idx;
    entry_t           hit_entry;
    logic             s_fire;
    logic             commit;
    status_t          res_status;
    logic [IW-1:0]    res_idx;
    entry_t           res_entry;
    logic [IW+3:0]    res_idx_wide;
    logic [CW+4:0]    count_wide;

    assign s_axis_tready = !cmd_valid_reg;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign commit        = cmd_valid_reg && cmp_done_reg && (!out_valid_reg || m_axis_tready);
    assign full          = count_reg >= CW'(MAX_REGIONS);

    // Sorted order makes the "start not above new start" flags a prefix, so the
    // insert slot is the first cell past it; the lowest loose hit is isolated
    // by the two's-complement trick.
    assign ins_onehot  = ~ge_vec & ((ge_vec << 1) | MAX_REGIONS'(1));
    assign strict_sel  = lh_vec & strict_vec;
    assign strict_hit  = |strict_sel;
    assign first_loose = loose_vec & (~loose_vec + MAX_REGIONS'(1));
    assign hit_sel     = strict_hit ? strict_sel : first_loose;
    assign any_hit     = |hit_sel;

    always_comb
    begin
        ins_idx   = '0;
        hit_idx   = '0;
        hit_entry = '0;
        for (int i = 0; i < MAX_REGIONS; i++)
        begin
            if (ins_onehot[i])
            begin
                ins_idx = ins_idx | IW'(i);
            end
            if (hit_sel[i])
            begin
                hit_idx   = hit_idx | IW'(i);
                hit_entry = entry_t'(hit_entry | cell_entry[i]);
            end
        end
    end

    always_comb
    begin
        res_status = ST_OK;
        res_idx    = '0;
        res_entry  = '0;
        count_next = count_reg;
        unique case (cmd_action_reg)
            ACT_INSERT:
            begin
                if (full)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    res_idx    = ins_idx;
                    count_next = count_reg + CW'(1);
                end
            end
            ACT_LOOKUP:
            begin
                if (any_hit)
                begin
                    res_idx   = hit_idx;
                    res_entry = hit_entry;
                end
                else
                begin
                    res_status = ST_MISS;
                end
            end
            ACT_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < MAX_REGIONS; g++)
        begin : g_cell
            assign valid_vec[g]  = count_reg > CW'(g);
            assign ge_vec[g]     = cell_flags[g].ge;
            assign strict_vec[g] = cell_flags[g].strict_hit;
            assign loose_vec[g]  = cell_flags[g].loose_hit;

            always_comb
            begin
                cell_ctrl[g].op       = CELL_HOLD;
                cell_ctrl[g].lh_load  = 1'b0;
                cell_ctrl[g].lh_value = 1'b0;
                cell_ctrl[g].flag_en  = cmd_valid_reg && !cmp_done_reg;
                if (commit)
                begin
                    case (cmd_action_reg)
                        ACT_INSERT:
                        begin
                            if (!full && !ge_vec[g])
                            begin
                                cell_ctrl[g].op = ins_onehot[g] ? CELL_LOAD : CELL_SHIFT;
                            end
                        end
                        ACT_LOOKUP:
                        begin
                            cell_ctrl[g].lh_load  = !strict_hit && any_hit;
                            cell_ctrl[g].lh_value = first_loose[g];
                        end
                        ACT_CLEAR:
                        begin
                            cell_ctrl[g].lh_load = 1'b1;
                        end
                        default:
                        begin
                            cell_ctrl[g].op = CELL_HOLD;
                        end
                    endcase
                end
            end

            if (g == 0)
            begin : g_first
                arg_cell u_cell (
                    .clk            (clk),
                    .rst_n          (rst_n),
                    .ctrl           (cell_ctrl[g]),
                    .new_entry      (cmd_entry_reg),
                    .lookup_address (cmd_addr_reg),
                    .entry_valid    (valid_vec[g]),
                    .prev_entry     (cmd_entry_reg),
                    .prev_last_hit  (1'b0),
                    .entry          (cell_entry[g]),
                    .last_hit       (lh_vec[g]),
                    .flags          (cell_flags[g])
                );
            end
            else
            begin : g_rest
                arg_cell u_cell (
                    .clk            (clk),
                    .rst_n          (rst_n),
                    .ctrl           (cell_ctrl[g]),
                    .new_entry      (cmd_entry_reg),
                    .lookup_address (cmd_addr_reg),
                    .entry_valid    (valid_vec[g]),
                    .prev_entry     (cell_entry[g-1]),
                    .prev_last_hit  (lh_vec[g-1]),
                    .entry          (cell_entry[g]),
                    .last_hit       (lh_vec[g]),
                    .flags          (cell_flags[g])
                );
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            cmd_action_reg           <= s_axis_tuser;
            cmd_entry_reg.start_addr <= s_axis_tdata[31:0];
            cmd_entry_reg.end_addr   <= s_axis_tdata[63:32];
            cmd_entry_reg.flags      <= s_axis_tdata[71:64];
            cmd_addr_reg             <= s_axis_tdata[103:72];
        end
        if (commit)
        begin
            out_status_reg <= res_status;
            out_index_reg  <= res_idx_wide[3:0];
            out_entry_reg  <= res_entry;
            out_count_reg  <= count_wide[4:0];
        end
    end

    assign res_idx_wide = {4'b0, res_idx};
    assign count_wide   = {5'b0, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            cmp_done_reg  <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                cmd_valid_reg <= 1'b1;
                cmp_done_reg  <= 1'b0;
            end
            else if (commit)
            begin
                cmd_valid_reg <= 1'b0;
                cmp_done_reg  <= 1'b0;
            end
            else if (cmd_valid_reg)
            begin
                cmp_done_reg <= 1'b1;
            end
            if (commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {7'b0, out_count_reg, out_entry_reg.flags, out_entry_reg.end_addr,
                            out_entry_reg.start_addr, out_index_reg};

    // At most one region carries the last-hit mark.
    a_lh_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(lh_vec))
        else $error("more than one last-hit mark");

    // The last-hit mark never sits on an empty slot.
    a_lh_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (lh_vec & ~valid_vec) == '0)
        else $error("last-hit mark outside the table");

    // The region count stays within the table size.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_REGIONS))
        else $error("region count above table size");

    // An accepted transfer always passes through the compare phase before it commits.
    a_compare: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> (cmd_valid_reg && !cmp_done_reg && !commit))
        else $error("transfer committed without compare phase");

endmodule

// File: tb/sv/address_region_table_tb.sv
// ============================================================================
// address_region_table_tb - self-checking bench for the address region table
// Streams insert, lookup, clear and unused-code operations into the table with random
// gaps, stalls the result side at random, and checks every result against
// a shadow copy of the sorted table and its last-hit cache.
// ============================================================================
module address_region_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import arg_pkg::*;

    localparam int          MAX_REGIONS = 16;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          OP_TARGET   = 600;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;

    typedef struct {
        logic [1:0]  action;
        entry_t      region;
        logic [31:0] address;
        int          gap;
    } table_op_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  index;
        logic [31:0] start_addr;
        logic [31:0] end_addr;
        logic [7:0]  flags;
        logic [4:0]  count;
    } table_result_t;

    logic          clk;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [103:0]  s_axis_tdata;   // region_start, region_end, region_flags, lookup_address
    logic [1:0]    s_axis_tuser;   // action
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [87:0]   m_axis_tdata;   // region_index, found_start, found_end, found_flags,
                                   // region_count, zero pad
    logic [1:0]    m_axis_tuser;   // status

    table_op_t     pending_ops[$];
    table_result_t expected_results[$];
    logic [31:0]   aim_starts[$];
    logic [31:0]   aim_ends[$];

    // Shadow copy of the table and its last-hit cache.
    entry_t        shadow_regions[MAX_REGIONS];
    int            shadow_count;
    bit            last_hit_valid;
    int            last_hit_index;

    int            ops_total;
    int            ops_accepted;
    int            results_seen;
    int            error_count;
    int            gap_waited;
    int            stall_left;
    int            cycle_count = 0;

    address_region_table #(
        .MAX_REGIONS(MAX_REGIONS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    function automatic table_result_t apply_region_op(table_op_t op);
        table_result_t r;
        int            pos;
        int            idx;
        bit            hit;
        logic [31:0]   a;
        r = '0;
        r.status = ST_OK;
        pos = 0;
        idx = 0;
        hit = 0;
        a = op.address;
        case (op.action)
            ACT_INSERT:
            begin
                if (shadow_count >= MAX_REGIONS)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    while (pos < shadow_count &&
                           shadow_regions[pos].start_addr <= op.region.start_addr)
                        pos++;
                    for (int i = shadow_count; i > pos; i--)
                        shadow_regions[i] = shadow_regions[i - 1];
                    shadow_regions[pos] = op.region;
                    shadow_count++;
                    // The cached index follows its region when the row shifts.
                    if (last_hit_valid && last_hit_index >= pos)
                        last_hit_index++;
                    r.index = pos[3:0];
                end
            end
            ACT_LOOKUP:
            begin
                if (last_hit_valid && last_hit_index < shadow_count &&
                    shadow_regions[last_hit_index].start_addr < a &&
                    a < shadow_regions[last_hit_index].end_addr)
                begin
                    hit = 1;
                    idx = last_hit_index;
                end
                else
                begin
                    for (int i = 0; i < shadow_count && !hit; i++)
                    begin
                        if (shadow_regions[i].start_addr <= a &&
                            a < shadow_regions[i].end_addr)
                        begin
                            hit = 1;
                            idx = i;
                            last_hit_valid = 1;
                            last_hit_index = i;
                        end
                    end
                end
                if (hit)
                begin
                    r.index      = idx[3:0];
                    r.start_addr = shadow_regions[idx].start_addr;
                    r.end_addr   = shadow_regions[idx].end_addr;
                    r.flags      = shadow_regions[idx].flags;
                end
                else
                begin
                    r.status = ST_MISS;
                end
            end
            ACT_CLEAR:
            begin
                shadow_count   = 0;
                last_hit_valid = 0;
                last_hit_index = 0;
            end
            default:
            begin
            end
        endcase
        r.count = shadow_count[4:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at result %0d: %s is %h, expected %h",
                 results_seen, what, got, want);
        error_count++;
    endtask

    task automatic push_op(logic [1:0] action, logic [31:0] rs, logic [31:0] re,
                           logic [7:0] rf, logic [31:0] addr);
        table_op_t op;
        op.action           = action;
        op.region.start_addr = rs;
        op.region.end_addr   = re;
        op.region.flags      = rf;
        op.address          = addr;
        // Every fourth stretch of operations goes back to back.
        op.gap = ((pending_ops.size() / 48) % 4 == 1) ? 0 : $urandom_range(0, 11);
        pending_ops.push_back(op);
        if (action == ACT_CLEAR)
        begin
            aim_starts.delete();
            aim_ends.delete();
        end
        else if (action == ACT_INSERT)
        begin
            aim_starts.push_back(rs);
            aim_ends.push_back(re);
        end
    endtask

    task automatic push_random_insert();
        logic [31:0] s;
        logic [31:0] e;
        int          r;
        r = $urandom_range(0, 19);
        if (r < 12)
        begin
            s = $urandom_range(0, 8191);
            e = s + $urandom_range(1, 1024);
        end
        else if (r < 15)
        begin
            s = $urandom;
            e = s + $urandom_range(1, 4096);
        end
        else if (r < 17)
        begin
            s = $urandom;
            e = $urandom;
        end
        else if (r == 17)
        begin
            s = $urandom_range(0, 8191);
            e = s;
        end
        else
        begin
            s = $urandom_range(0, 8191);
            e = s - $urandom_range(1, 64);
        end
        push_op(ACT_INSERT, s, e, $urandom_range(0, 255), $urandom);
    endtask

    task automatic push_random_lookup();
        logic [31:0] s;
        logic [31:0] e;
        logic [31:0] a;
        int          r;
        int          k;
        r = $urandom_range(0, 9);
        a = $urandom;
        if (aim_starts.size() > 0 && r < 9)
        begin
            k = $urandom_range(0, aim_starts.size() - 1);
            s = aim_starts[k];
            e = aim_ends[k];
            case (r)
                5: a = s;
                6: a = e - 1;
                7: a = e;
                8: a = s - 1;
                default: a = (e > s) ? s + ($urandom % (e - s)) : s;
            endcase
        end
        push_op(ACT_LOOKUP, $urandom, $urandom, $urandom_range(0, 255), a);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Directed operations, then random episodes of inserts and lookups.
    initial
    begin
        int n_ins;
        int n_look;
        rst_n = 1'b0;
        shadow_count   = 0;
        last_hit_valid = 0;
        last_hit_index = 0;
        for (int i = 0; i < MAX_REGIONS; i++)
            shadow_regions[i] = '0;

        push_op(ACT_LOOKUP, 32'h0, 32'h0, 8'h00, 32'h0000_0000);
        push_op(ACT_UNUSED, 32'h0, 32'h0, 8'h00, 32'h0000_0000);
        push_op(ACT_INSERT, 32'h0000_1000, 32'h0000_2000, 8'h5A, 32'hFFFF_FFFF);
        push_op(ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF, 32'h0000_0000);
        push_op(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'h0000_0000);
        push_op(ACT_LOOKUP, 32'h0, 32'h0, 8'h00, 32'h0000_1800);
        push_op(ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 32'h0);
        push_op(ACT_INSERT, 32'h0000_1000, 32'h0000_1800, 8'hA5, 32'h0);
        push_op(ACT_INSERT, 32'h0000_0000, 32'h0000_0010, 8'h01, 32'h0);
        push_op(ACT_LOOKUP, 32'h0, 32'h0, 8'h00, 32'hFFFF_FFFF);
        push_op(ACT_LOOKUP, 32'h0, 32'h0, 8'h00, 32'hFFFF_FFFE);
        push_op(ACT_LOOKUP, 32'h0, 32'h0, 8'h00, 32'h0000_1000);
        push_op(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        push_op(ACT_LOOKUP, 32'h0, 32'h0, 8'h00, 32'h0000_1000);
        push_op(ACT_INSERT, 32'h0000_0100, 32'h0000_0200, 8'h11, 32'h0);
        push_op(ACT_LOOKUP, 32'h0, 32'h0, 8'h00, 32'h0000_0100);
        push_op(ACT_INSERT, 32'h0000_0000, 32'h0000_0080, 8'h22, 32'h0);
        push_op(ACT_LOOKUP, 32'h0, 32'h0, 8'h00, 32'h0000_0150);
        push_op(ACT_LOOKUP, 32'h0, 32'h0, 8'h00, 32'h0000_01FF);
        push_op(ACT_LOOKUP, 32'h0, 32'h0, 8'h00, 32'h0000_0200);
        push_op(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        push_op(ACT_LOOKUP, 32'h0, 32'h0, 8'h00, 32'h0000_0040);

        // Most episodes start from an empty table; some keep filling the table left by the one before.
        while (pending_ops.size() < OP_TARGET)
        begin
            if ($urandom_range(0, 4) != 0)
                push_op(ACT_CLEAR, $urandom, $urandom, $urandom_range(0, 255), $urandom);
            n_ins  = $urandom_range(1, 20);
            n_look = $urandom_range(n_ins, 3 * n_ins);
            while (n_ins > 0 || n_look > 0)
            begin
                if ($urandom_range(0, 39) == 0)
                    push_op(ACT_UNUSED, $urandom, $urandom, $urandom_range(0, 255),
                            $urandom);
                else if (n_ins > 0 && (n_look == 0 || $urandom_range(0, 2) == 0))
                begin
                    push_random_insert();
                    n_ins--;
                end
                else
                begin
                    push_random_lookup();
                    n_look--;
                end
            end
        end
        ops_total = pending_ops.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (!(ops_accepted == ops_total && expected_results.size() == 0))
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("** address_region_table: PASSED **");
        else
            $display("** address_region_table: FAILED **");
        $finish;
    end

    // Driver: each operation waits its own gap, then holds until taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            ops_accepted  <= 0;
            gap_waited    <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(apply_region_op(pending_ops.pop_front()));
                ops_accepted <= ops_accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_ops.size() == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                end
                else if (gap_waited < pending_ops[0].gap)
                begin
                    s_axis_tvalid <= 1'b0;
                    gap_waited    <= gap_waited + 1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_ops[0].action;
                    s_axis_tdata  <= {pending_ops[0].address, pending_ops[0].region.flags,
                                      pending_ops[0].region.end_addr,
                                      pending_ops[0].region.start_addr};
                    gap_waited    <= 0;
                end
            end
        end
    end

    // Monitor: checks each result transfer and draws the stall before the next.
    always @(posedge clk or negedge rst_n)
    begin
        table_result_t want;
        int            stall;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            results_seen  <= 0;
            error_count   = 0;
        end
        else
        begin
            stall = stall_left;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result, status", m_axis_tuser, '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", m_axis_tuser, want.status);
                    if (m_axis_tdata[3:0] !== want.index)
                        report_mismatch("region_index", m_axis_tdata[3:0], want.index);
                    if (m_axis_tdata[35:4] !== want.start_addr)
                        report_mismatch("found_start", m_axis_tdata[35:4], want.start_addr);
                    if (m_axis_tdata[67:36] !== want.end_addr)
                        report_mismatch("found_end", m_axis_tdata[67:36], want.end_addr);
                    if (m_axis_tdata[75:68] !== want.flags)
                        report_mismatch("found_flags", m_axis_tdata[75:68], want.flags);
                    if (m_axis_tdata[80:76] !== want.count)
                        report_mismatch("region_count", m_axis_tdata[80:76], want.count);
                end
                results_seen <= results_seen + 1;
                stall = ((results_seen / 56) % 3 == 2) ? 0 : $urandom_range(0, 11);
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left    <= stall - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left    <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** address_region_table: FAILED **");
            $finish;
        end
    end

endmodule
